@@ hdl/scpr_pkg.sv @@
package scpr_pkg;

  localparam int MAX_FRAMES = 64;
  localparam int FRAME_W    = $clog2(MAX_FRAMES);
  localparam int COUNT_W    = 7;
  localparam int PAGE_BITS  = 16;
  localparam int FAULT_W    = 16;

  localparam logic [COUNT_W-1:0] FRAMES_RESET = COUNT_W'(4);
  localparam logic [FAULT_W-1:0] FAULT_TOP    = {FAULT_W{1'b1}};

  typedef logic [FRAME_W-1:0]   frame_idx_t;
  typedef logic [COUNT_W-1:0]   frame_cnt_t;
  typedef logic [PAGE_BITS-1:0] page_t;
  typedef logic [FAULT_W-1:0]   fault_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SWEEP,
    ST_EVICT,
    ST_DONE
  } state_e;

endpackage

@@ hdl/scpr_if.sv @@
interface scpr_in_if import scpr_pkg::*; ();
  logic  valid;
  logic  ready;
  page_t page;
  logic  first_ref;

  modport source (output valid, output page, output first_ref, input ready);
  modport sink   (input valid, input page, input first_ref, output ready);
endinterface

interface scpr_out_if import scpr_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       hit;
  frame_idx_t frame_index;
  logic       evicted_valid;
  page_t      evicted_page;
  fault_t     fault_count;

  modport source (output valid, output hit, output frame_index, output evicted_valid,
                  output evicted_page, output fault_count, input ready);
  modport sink   (input valid, input hit, input frame_index, input evicted_valid,
                  input evicted_page, input fault_count, output ready);
endinterface

@@ hdl/second_chance_page_replacer_core.sv @@
// Channel  Direction  Payload                                              Handshake
// in_i     sink       page, first_ref                                      valid/ready
// out_o    source     hit, frame_index, evicted_valid, evicted_page,       valid/ready
//                     fault_count
// cfg      input      frames_in_use (cfg_wdata_i)                          cfg_we_i
//
// One reference is processed at a time. The lookup reads the page memory one
// frame per cycle and stops at a hit; a miss scans all n managed frames, then
// the hand passes each set used bit, clearing it, and the eviction read, the
// write back and the result load follow. Reset clears the valid and used
// flip-flops at once, so no clearing pass is needed.
// A stalled output holds the finished result while the next reference is accepted.
module second_chance_page_replacer_core import scpr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  frame_cnt_t cfg_wdata_i,
  scpr_in_if.sink    in_i,
  scpr_out_if.source out_o
);

  state_e     state_q, state_d;
  frame_cnt_t cfg_q;
  frame_cnt_t n_q, n_d;
  page_t      page_q, page_d;
  frame_cnt_t idx_q, idx_d;
  logic       cmp_v_q, cmp_v_d;
  frame_idx_t cmp_idx_q, cmp_idx_d;
  frame_idx_t hand_q, hand_d;
  fault_t     faults_q, faults_d;
  logic [MAX_FRAMES-1:0] valid_q, valid_d;
  logic [MAX_FRAMES-1:0] used_q, used_d;
  frame_idx_t slot_q, slot_d;
  logic       res_hit_q, res_hit_d;
  logic       res_ev_v_q, res_ev_v_d;
  page_t      res_ev_page_q, res_ev_page_d;

  logic       out_valid_q, out_valid_d;
  logic       out_hit_q, out_ev_v_q;
  frame_idx_t out_idx_q;
  page_t      out_ev_page_q;
  fault_t     out_faults_q;
  logic       out_load;

  page_t      mem [MAX_FRAMES];
  page_t      rdata_q;
  logic       mem_re, mem_we;
  frame_idx_t mem_raddr;

  frame_cnt_t n_new;
  frame_idx_t hand_new;
  logic       match;

  function automatic frame_idx_t step_hand(frame_idx_t h, frame_cnt_t n);
    frame_cnt_t nxt;
    nxt = {1'b0, h} + frame_cnt_t'(1);
    step_hand = (nxt >= n) ? '0 : nxt[FRAME_W-1:0];
  endfunction

  assign in_i.ready = (state_q == ST_IDLE);

  always_comb begin
    if (cfg_q == '0) begin
      n_new = frame_cnt_t'(1);
    end else if (cfg_q > frame_cnt_t'(MAX_FRAMES)) begin
      n_new = frame_cnt_t'(MAX_FRAMES);
    end else begin
      n_new = cfg_q;
    end
    hand_new = in_i.first_ref ? '0 : hand_q;
    if ({1'b0, hand_new} >= n_new) begin
      hand_new = '0;
    end
  end

  assign match = cmp_v_q && valid_q[cmp_idx_q] && (rdata_q == page_q);

  always_comb begin
    state_d       = state_q;
    n_d           = n_q;
    page_d        = page_q;
    idx_d         = idx_q;
    cmp_v_d       = 1'b0;
    cmp_idx_d     = cmp_idx_q;
    hand_d        = hand_q;
    faults_d      = faults_q;
    valid_d       = valid_q;
    used_d        = used_q;
    slot_d        = slot_q;
    res_hit_d     = res_hit_q;
    res_ev_v_d    = res_ev_v_q;
    res_ev_page_d = res_ev_page_q;
    mem_re        = 1'b0;
    mem_we        = 1'b0;
    mem_raddr     = idx_q[FRAME_W-1:0];
    out_load      = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          n_d    = n_new;
          page_d = in_i.page;
          hand_d = hand_new;
          idx_d  = '0;
          if (in_i.first_ref) begin
            valid_d  = '0;
            used_d   = '0;
            faults_d = '0;
          end
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (match) begin
          used_d[cmp_idx_q] = 1'b1;
          slot_d        = cmp_idx_q;
          res_hit_d     = 1'b1;
          res_ev_v_d    = 1'b0;
          res_ev_page_d = '0;
          state_d       = ST_DONE;
        end else if (idx_q < n_q) begin
          mem_re    = 1'b1;
          cmp_v_d   = 1'b1;
          cmp_idx_d = idx_q[FRAME_W-1:0];
          idx_d     = idx_q + frame_cnt_t'(1);
        end else begin
          if (faults_q != FAULT_TOP) begin
            faults_d = faults_q + fault_t'(1);
          end
          res_hit_d = 1'b0;
          state_d   = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (used_q[hand_q]) begin
          used_d[hand_q] = 1'b0;
          hand_d         = step_hand(hand_q, n_q);
        end else begin
          mem_re    = 1'b1;
          mem_raddr = hand_q;
          slot_d    = hand_q;
          state_d   = ST_EVICT;
        end
      end
      ST_EVICT: begin
        mem_we          = 1'b1;
        res_ev_v_d      = valid_q[slot_q];
        res_ev_page_d   = valid_q[slot_q] ? rdata_q : '0;
        valid_d[slot_q] = 1'b1;
        used_d[slot_q]  = 1'b1;
        hand_d          = step_hand(slot_q, n_q);
        state_d         = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[slot_q] <= page_q;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_q       <= FRAMES_RESET;
      n_q         <= frame_cnt_t'(1);
      idx_q       <= '0;
      cmp_v_q     <= 1'b0;
      hand_q      <= '0;
      faults_q    <= '0;
      valid_q     <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      n_q         <= n_d;
      idx_q       <= idx_d;
      cmp_v_q     <= cmp_v_d;
      hand_q      <= hand_d;
      faults_q    <= faults_d;
      valid_q     <= valid_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q        <= page_d;
    cmp_idx_q     <= cmp_idx_d;
    slot_q        <= slot_d;
    res_hit_q     <= res_hit_d;
    res_ev_v_q    <= res_ev_v_d;
    res_ev_page_q <= res_ev_page_d;
    if (out_load) begin
      out_hit_q     <= res_hit_q;
      out_idx_q     <= slot_q;
      out_ev_v_q    <= res_ev_v_q;
      out_ev_page_q <= res_ev_page_q;
      out_faults_q  <= faults_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.hit           = out_hit_q;
  assign out_o.frame_index   = out_idx_q;
  assign out_o.evicted_valid = out_ev_v_q;
  assign out_o.evicted_page  = out_ev_page_q;
  assign out_o.fault_count   = out_faults_q;

  // A hit never evicts, and an empty eviction reports page zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !(out_o.hit && out_o.evicted_valid))
    else $error("hit reported together with an eviction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.evicted_valid) |-> (out_o.evicted_page == '0))
    else $error("evicted page not zero without an eviction");

  // The hand stays inside the managed frames while a reference is in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> ({1'b0, hand_q} < n_q))
    else $error("clock hand outside the managed frames");

  // The frame chosen for eviction is valid and marked used after write back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVICT) |=> (valid_q[slot_q] && used_q[slot_q]))
    else $error("loaded frame not marked valid and used");

endmodule

@@ tb/tb.sv @@
module tb;
  import scpr_pkg::*;

  localparam int LIMIT_CYCLES  = 4_000_000;
  localparam int REPORT_MAX    = 10;
  localparam int PHASE_REFS    = 205;

  typedef struct packed {
    logic       hit;
    frame_idx_t frame_index;
    logic       evicted_valid;
    page_t      evicted_page;
    fault_t     fault_count;
  } ref_result_t;

  class page_ref_scoreboard;
    page_t       frame_page[MAX_FRAMES];
    bit          frame_valid[MAX_FRAMES];
    bit          used[MAX_FRAMES];
    int          hand;
    fault_t      faults;
    frame_cnt_t  frames_cfg = FRAMES_RESET;
    ref_result_t expected_results[$];
    int          mismatches;
    int          checked;

    function void clear_run();
      foreach (frame_valid[i]) begin
        frame_valid[i] = 1'b0;
        used[i]        = 1'b0;
      end
      hand   = 0;
      faults = '0;
    endfunction

    function int active_frames();
      if (frames_cfg == 0) return 1;
      if (frames_cfg > MAX_FRAMES) return MAX_FRAMES;
      return int'(frames_cfg);
    endfunction

    function void note_ref(page_t pg, logic first);
      int          n;
      int          slot;
      bit          found;
      ref_result_t r;
      n     = active_frames();
      slot  = 0;
      found = 1'b0;
      r     = '0;
      if (first) clear_run();
      if (hand >= n) hand = 0;
      for (int i = 0; i < n && !found; i++) begin
        if (frame_valid[i] && frame_page[i] == pg) begin
          slot  = i;
          found = 1'b1;
        end
      end
      if (found) begin
        used[slot] = 1'b1;
      end else begin
        if (faults != FAULT_TOP) faults++;
        while (used[hand]) begin
          used[hand] = 1'b0;
          hand       = (hand + 1 >= n) ? 0 : hand + 1;
        end
        slot = hand;
        if (frame_valid[slot]) begin
          r.evicted_valid = 1'b1;
          r.evicted_page  = frame_page[slot];
        end
        frame_page[slot]  = pg;
        frame_valid[slot] = 1'b1;
        used[slot]        = 1'b1;
        hand              = (hand + 1 >= n) ? 0 : hand + 1;
      end
      r.hit         = found;
      r.frame_index = frame_idx_t'(slot);
      r.fault_count = faults;
      expected_results.push_back(r);
    endfunction

    function void check_result(ref_result_t got);
      ref_result_t want;
      checked++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("ERROR: result with no reference pending: hit=%0b frame=%0d ev=%0b/%h faults=%0d",
                   got.hit, got.frame_index, got.evicted_valid, got.evicted_page,
                   got.fault_count);
        return;
      end
      want = expected_results.pop_front();
      if (got.hit !== want.hit || got.frame_index !== want.frame_index ||
          got.evicted_valid !== want.evicted_valid || got.evicted_page !== want.evicted_page ||
          got.fault_count !== want.fault_count) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("ERROR: result %0d expected hit=%0b frame=%0d ev=%0b/%h faults=%0d",
                   checked, want.hit, want.frame_index, want.evicted_valid, want.evicted_page,
                   want.fault_count);
          $display("       got                 hit=%0b frame=%0d ev=%0b/%h faults=%0d",
                   got.hit, got.frame_index, got.evicted_valid, got.evicted_page,
                   got.fault_count);
        end
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  frame_cnt_t cfg_wdata_i;
  int         send_idle_pct;
  int         recv_stall_pct;
  int         cycles;

  page_ref_scoreboard sb = new();

  scpr_in_if  in_if ();
  scpr_out_if out_if ();

  second_chance_page_replacer_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Every transaction on either channel is sampled at the edge that completes it.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) sb.note_ref(in_if.page, in_if.first_ref);
      if (out_if.valid && out_if.ready)
        sb.check_result('{out_if.hit, out_if.frame_index, out_if.evicted_valid,
                          out_if.evicted_page, out_if.fault_count});
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycles,
               sb.expected_results.size());
      $display("second_chance_page_replacer_core: mismatch");
      $finish;
    end
  end

  task automatic send_ref(input page_t pg, input logic first);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.page      <= pg;
    in_if.first_ref <= first;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_frames(input frame_cnt_t value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    sb.frames_cfg = value;
  endtask

  task automatic run_directed();
    send_ref(16'h0000, 1'b1);
    send_ref(16'hFFFF, 1'b0);
    send_ref(16'h0000, 1'b0);
    send_ref(16'hFFFF, 1'b0);
    send_ref(16'h1234, 1'b0);
    send_ref(16'hABCD, 1'b0);
    send_ref(16'h5555, 1'b0);
    send_ref(16'hFFFF, 1'b0);
    send_ref(16'hAAAA, 1'b0);
    write_frames(frame_cnt_t'(8));
    send_ref(16'h0101, 1'b0);
    send_ref(16'h0202, 1'b0);
    send_ref(16'h0303, 1'b0);
    send_ref(16'h0404, 1'b0);
    send_ref(16'h0505, 1'b0);
    // Lowering the count leaves the hand and some pages beyond it.
    write_frames(frame_cnt_t'(3));
    send_ref(16'h0505, 1'b0);
    send_ref(16'h0404, 1'b0);
    write_frames(frame_cnt_t'(8));
    send_ref(16'h0505, 1'b0);
    send_ref(16'h0404, 1'b0);
    write_frames(frame_cnt_t'(0));
    send_ref(16'h8000, 1'b1);
    send_ref(16'h7FFF, 1'b0);
    send_ref(16'h7FFF, 1'b0);
    write_frames(frame_cnt_t'(127));
    send_ref(16'h4242, 1'b1);
    send_ref(16'h4242, 1'b0);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input frame_cnt_t cfg);
    page_t pool[$];
    int    n;
    int    pick;
    logic  first;
    page_t pg;
    write_frames(cfg);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    n = sb.active_frames();
    repeat ($urandom_range(n / 2 + 1, n + n / 4 + 2))
      pool.push_back(page_t'($urandom_range(0, 65535)));
    for (int k = 0; k < PHASE_REFS; k++) begin
      pick  = $urandom_range(99);
      first = (k == 0) ? logic'($urandom_range(1)) : (pick < 3);
      if (pick < 85) pg = pool[$urandom_range(pool.size() - 1)];
      else pg = page_t'($urandom_range(0, 65535));
      if (pick == 40) pool[$urandom_range(pool.size() - 1)] = page_t'($urandom_range(0, 65535));
      send_ref(pg, first);
    end
  endtask

  initial begin
    int         idle_mode[4];
    int         stall_mode[4];
    frame_cnt_t cfgs[8];
    idle_mode  = '{0, 58, 0, 29};
    stall_mode = '{0, 0, 58, 29};
    cfgs = '{frame_cnt_t'(1), frame_cnt_t'(64), frame_cnt_t'(2), frame_cnt_t'(127),
             frame_cnt_t'(0), frame_cnt_t'(16), frame_cnt_t'($urandom_range(1, 64)),
             frame_cnt_t'($urandom_range(0, 127))};
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_wdata_i     <= '0;
    in_if.valid     <= 1'b0;
    in_if.page      <= '0;
    in_if.first_ref <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    for (int m = 0; m < 4; m++) begin
      run_phase(idle_mode[m], stall_mode[m], cfgs[2 * m]);
      run_phase(idle_mode[m], stall_mode[m], cfgs[2 * m + 1]);
    end

    write_frames(frame_cnt_t'(1));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_ref(16'h0000, 1'b1);
    send_ref(16'h0001, 1'b0);
    send_ref(16'h00FF, 1'b1);

    drain();
    repeat (140) @(posedge clk_i);
    $display("Checked %0d results: directed corner cases, eight random phases with frame",
             sb.checked);
    $display("counts from 0 to 127 under four idle/stall mixes, and a closing restart.");
    if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
      $display("second_chance_page_replacer_core: match");
    end else begin
      $display("second_chance_page_replacer_core: mismatch");
    end
    $finish;
  end

endmodule
